// ===== hw/rtl/byte_level_pretokenizer_assert.svh =====
// Assertion macros used by the checker file.
// Each macro expects aclk and aresetn to exist in the enclosing scope.
`ifndef BYTE_LEVEL_PRETOKENIZER_ASSERT_SVH
`define BYTE_LEVEL_PRETOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BLTOK_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLTOK_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ===== hw/rtl/bltok_pkg.sv =====
package bltok_pkg;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_LETTER = 3'd1,
        CLS_DIGIT  = 3'd2,
        CLS_WSPACE = 3'd3,
        CLS_PUNCT  = 3'd4
    } cls_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       piece_start;
        logic       text_done;
    } item_t;

    localparam logic [7:0] CHAR_APOS  = 8'h27;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LC_D  = 8'h64;
    localparam logic [7:0] CHAR_LC_E  = 8'h65;
    localparam logic [7:0] CHAR_LC_L  = 8'h6C;
    localparam logic [7:0] CHAR_LC_M  = 8'h6D;
    localparam logic [7:0] CHAR_LC_R  = 8'h72;
    localparam logic [7:0] CHAR_LC_S  = 8'h73;
    localparam logic [7:0] CHAR_LC_T  = 8'h74;
    localparam logic [7:0] CHAR_LC_V  = 8'h76;

endpackage

// ===== hw/rtl/bltok_front.sv =====
module bltok_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    input  logic                s_end_of_text,
    output logic                push_valid,
    input  logic                push_ready,
    output bltok_pkg::item_t    push_item
);

    function automatic logic is_ws(input logic [7:0] c);
        return (c == bltok_pkg::CHAR_SPACE) ||
               (c >= bltok_pkg::CHAR_TAB && c <= bltok_pkg::CHAR_CR);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= bltok_pkg::CHAR_LC_A && c <= bltok_pkg::CHAR_LC_Z) ||
               (c >= bltok_pkg::CHAR_UC_A && c <= bltok_pkg::CHAR_UC_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= bltok_pkg::CHAR_0 && c <= bltok_pkg::CHAR_9;
    endfunction

    function automatic bltok_pkg::cls_t class_of(input logic [7:0] c);
        if (is_ws(c))          return bltok_pkg::CLS_WSPACE;
        else if (is_letter(c)) return bltok_pkg::CLS_LETTER;
        else if (is_digit(c))  return bltok_pkg::CLS_DIGIT;
        else                   return bltok_pkg::CLS_PUNCT;
    endfunction

    logic [7:0]        win_reg [0:2];
    logic [7:0]        win_next [0:2];
    logic [1:0]        count_reg, count_next;
    logic              final_reg, final_next;
    bltok_pkg::cls_t   cls_reg, cls_next;
    logic [1:0]        cl_reg, cl_next;
    logic              lsp_reg, lsp_next;

    logic [7:0]        c, w1, w2;
    logic [1:0]        ctr_len;
    logic              ctr_wait;
    logic              run_cont, c_apos, c_punct;
    logic              decided, start, pop, accept, last_pop;
    logic [1:0]        idx;

    assign c  = win_reg[0];
    assign w1 = win_reg[1];
    assign w2 = win_reg[2];

    // contraction match at the window front
    always_comb begin
        ctr_len  = 2'd0;
        ctr_wait = 1'b0;
        if (c == bltok_pkg::CHAR_APOS) begin
            if (count_reg < 2'd2) begin
                ctr_wait = !final_reg;
            end else if (w1 == bltok_pkg::CHAR_LC_S || w1 == bltok_pkg::CHAR_LC_T ||
                         w1 == bltok_pkg::CHAR_LC_M || w1 == bltok_pkg::CHAR_LC_D) begin
                ctr_len = 2'd2;
            end else if (w1 == bltok_pkg::CHAR_LC_R || w1 == bltok_pkg::CHAR_LC_V ||
                         w1 == bltok_pkg::CHAR_LC_L) begin
                if (count_reg < 2'd3) begin
                    ctr_wait = !final_reg;
                end else if ((w1 == bltok_pkg::CHAR_LC_R && w2 == bltok_pkg::CHAR_LC_E) ||
                             (w1 == bltok_pkg::CHAR_LC_V && w2 == bltok_pkg::CHAR_LC_E) ||
                             (w1 == bltok_pkg::CHAR_LC_L && w2 == bltok_pkg::CHAR_LC_L)) begin
                    ctr_len = 2'd3;
                end
            end
        end
    end

    assign c_apos  = (c == bltok_pkg::CHAR_APOS);
    assign c_punct = !is_ws(c) && !is_letter(c) && !is_digit(c);
    assign run_cont =
        (cls_reg == bltok_pkg::CLS_LETTER && is_letter(c)) ||
        (cls_reg == bltok_pkg::CLS_DIGIT  && is_digit(c))  ||
        (cls_reg == bltok_pkg::CLS_WSPACE && is_ws(c) && c != bltok_pkg::CHAR_SPACE) ||
        (cls_reg == bltok_pkg::CLS_PUNCT  && c_punct && !c_apos);

    // piece decision for the front byte
    always_comb begin
        decided  = 1'b1;
        start    = 1'b1;
        cls_next = cls_reg;
        cl_next  = cl_reg;
        lsp_next = lsp_reg;
        priority if (cl_reg != 2'd0) begin
            start   = 1'b0;
            cl_next = cl_reg - 2'd1;
        end else if (lsp_reg) begin
            start    = 1'b0;
            lsp_next = 1'b0;
            if (is_letter(c))     cls_next = bltok_pkg::CLS_LETTER;
            else if (is_digit(c)) cls_next = bltok_pkg::CLS_DIGIT;
            else                  cls_next = bltok_pkg::CLS_PUNCT;
        end else if (run_cont) begin
            start = 1'b0;
        end else if (c_apos && ctr_wait) begin
            decided = 1'b0;
        end else if (c_apos && cls_reg == bltok_pkg::CLS_PUNCT && ctr_len == 2'd0) begin
            start = 1'b0;
        end else if (c_apos && ctr_len != 2'd0) begin
            cl_next  = ctr_len - 2'd1;
            cls_next = bltok_pkg::CLS_NONE;
        end else if (c == bltok_pkg::CHAR_SPACE) begin
            if (count_reg < 2'd2 && !final_reg) begin
                decided = 1'b0;
            end else begin
                lsp_next = (count_reg >= 2'd2) && !is_ws(w1);
                cls_next = bltok_pkg::CLS_NONE;
            end
        end else begin
            cls_next = class_of(c);
        end
    end

    assign pop      = decided && (count_reg != 2'd0) && push_ready;
    assign last_pop = pop && final_reg && (count_reg == 2'd1);
    // a full window still takes a byte in the cycle its front byte leaves
    assign s_ready  = !final_reg && ((count_reg < 2'd3) || pop);
    assign accept   = s_valid && s_ready;
    assign idx      = count_reg - {1'b0, pop};

    assign push_valid            = decided && (count_reg != 2'd0);
    assign push_item.out_byte    = c;
    assign push_item.piece_start = start;
    assign push_item.text_done   = final_reg && (count_reg == 2'd1);

    // window shift and append
    always_comb begin
        win_next[0] = win_reg[0];
        win_next[1] = win_reg[1];
        win_next[2] = win_reg[2];
        if (pop) begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = 8'h00;
        end
        if (accept) begin
            win_next[idx] = s_text_byte;
        end
        count_next = count_reg - {1'b0, pop} + {1'b0, accept};
        final_next = (final_reg && !last_pop) || (accept && s_end_of_text);
    end

    always_ff @(posedge aclk) begin
        win_reg[0] <= win_next[0];
        win_reg[1] <= win_next[1];
        win_reg[2] <= win_next[2];
        if (!aresetn) begin
            count_reg <= 2'd0;
            final_reg <= 1'b0;
            cls_reg   <= bltok_pkg::CLS_NONE;
            cl_reg    <= 2'd0;
            lsp_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            final_reg <= final_next;
            if (last_pop) begin
                cls_reg <= bltok_pkg::CLS_NONE;
                cl_reg  <= 2'd0;
                lsp_reg <= 1'b0;
            end else if (pop) begin
                cls_reg <= cls_next;
                cl_reg  <= cl_next;
                lsp_reg <= lsp_next;
            end
        end
    end

endmodule

// ===== hw/rtl/bltok_queue.sv =====
module bltok_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  bltok_pkg::item_t    in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output bltok_pkg::item_t    out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bltok_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               wr_en, rd_en;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en) rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) slot_reg[wr_ptr_reg] <= in_item;
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/bltok_back.sv =====
module bltok_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  bltok_pkg::item_t    q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_piece_start,
    output logic                m_text_done
);

    logic               valid_reg, valid_next;
    bltok_pkg::item_t   item_reg;

    // load when the register is empty or its item leaves this cycle
    assign q_ready    = !valid_reg || m_ready;
    assign valid_next = q_valid || (valid_reg && !m_ready);

    assign m_valid       = valid_reg;
    assign m_out_byte    = item_reg.out_byte;
    assign m_piece_start = item_reg.piece_start;
    assign m_text_done   = item_reg.text_done;

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) item_reg <= q_item;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hw/rtl/byte_level_pretokenizer.sv =====
// Byte-level pre-tokenizer: text enters one byte per item on the s_ channel and
// leaves unchanged and in order on the m_ channel, each byte tagged with
// piece_start when it opens a new piece (contractions 're 've 'll 's 't 'm 'd,
// a space joined to the following word, number or symbol run, lone spaces,
// runs of other whitespace, letters, digits, and symbols including bytes 128
// and up) and text_done on the last byte of the text. Throughput is one byte
// per cycle while m_ready stays high and no text is draining, set by the front
// window logic, which decides one byte per cycle. A byte that needs lookahead
// (a space, or an apostrophe that may open a contraction) waits in a
// three-byte window until one or two following bytes arrive. A byte that needs
// no lookahead, with nothing waiting ahead of it, passes through the window
// register, the queue and the output register before m_valid rises. After a
// byte with end_of_text is accepted, s_ready stays low while the window drains
// and all run state returns to its reset value, so the next byte starts a
// fresh text. A queue of QUEUE_DEPTH items sits between the window and the
// output register, so the input keeps flowing while a result waits on m_ready.
module byte_level_pretokenizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_piece_start,
    output logic        m_text_done
);

    // decided items, front to queue
    logic               push_valid, push_ready;
    bltok_pkg::item_t   push_item;

    // queued items, queue to output register
    logic               q_valid, q_ready;
    bltok_pkg::item_t   q_item;

    // Front: hold the lookahead window, classify the front byte and decide
    // whether it opens a piece; advance one byte per cycle while push_ready holds.
    bltok_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // Queue: absorb output stalls so the front keeps deciding.
    bltok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Back: registered output stage driving the m_ channel.
    bltok_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_piece_start (m_piece_start),
        .m_text_done   (m_text_done)
    );

endmodule

// ===== hw/rtl/bltok_checker.sv =====
`include "byte_level_pretokenizer_assert.svh"

module bltok_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_piece_start,
    input  logic        m_text_done
);

    // high while the next delivered item is the first byte of a text
    logic text_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_start_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            text_start_reg <= m_text_done;
        end
    end

    `BLTOK_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable({s_text_byte, s_end_of_text}), "waiting input item changed")

    `BLTOK_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_piece_start) && $stable(m_text_done), "stalled result item changed")

    `BLTOK_ASSERT_NEXT(a_stall_after_end, s_valid && s_ready && s_end_of_text, !s_ready, "input taken before end-of-text flush")

    `BLTOK_ASSERT_NOW(a_first_byte_starts, m_valid && text_start_reg, m_piece_start, "first byte of a text does not open a piece")

endmodule

bind byte_level_pretokenizer bltok_checker u_bltok_checker (.*);
